FILE: hw/rtl/text_column_field_cut_filter_defines.svh
`ifndef TEXT_COLUMN_FIELD_CUT_FILTER_DEFINES_SVH
`define TEXT_COLUMN_FIELD_CUT_FILTER_DEFINES_SVH

// Check that holds at every clock edge outside reset.
`define TCF_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition seen at one edge brings a result at the next edge.
`define TCF_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

FILE: hw/rtl/tcfcut_pkg.sv
package tcfcut_pkg;

   localparam int BOUND_BITS  = 16;
   localparam int RANGE_SLOTS = 3;
   localparam int BYTE_BITS   = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic MODE_COLUMN = 1'b0;
   localparam logic MODE_FIELD  = 1'b1;

   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;

   localparam logic [BOUND_BITS-1:0] LOW_RESET  = 16'd1;
   localparam logic [BOUND_BITS-1:0] HIGH_RESET = 16'd0;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_A_LOW  = 3'd1,
      REG_A_HIGH = 3'd2,
      REG_B_LOW  = 3'd3,
      REG_B_HIGH = 3'd4,
      REG_C_LOW  = 3'd5,
      REG_C_HIGH = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                                   mode;
      logic [RANGE_SLOTS-1:0][BOUND_BITS-1:0] low;
      logic [RANGE_SLOTS-1:0][BOUND_BITS-1:0] high;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] text_byte;
      logic                 node_last;
   } item_type;

endpackage

FILE: hw/rtl/text_column_field_cut_filter.sv
// Path: a kept word is held in the input stage register, then in the output register, which
//   drives rsp_tvalid; while the output register is stalled the word waits in the input stage.
// Throughput: one word per cycle, but a kept word waits while the output register is stalled;
//   the input stage frees as it hands over, and a dropped word leaves it even during such a stall.
// Reset: synchronous, active high; clears both stage valids, the column counter to 1,
//   the field counter and token flag to 0, mode to columns and all intervals to empty.
module text_column_field_cut_filter
   import tcfcut_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int NUM_RANGES = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] text_byte
   input  logic                     req_tlast,   // node_last
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [7:0] kept_byte
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type  cfg;

   // input stage
   logic     in_valid_ff;
   logic     in_valid_in;
   item_type in_item_ff;

   // output stage
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [BYTE_BITS-1:0] out_byte_ff;

   logic req_accept;
   logic keep;
   logic advance;

   tcfcut_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcfcut_core #(
      .COUNT_BITS (COUNT_BITS),
      .NUM_RANGES (NUM_RANGES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_item_ff),
      .advance (advance),
      .keep    (keep)
   );

   // Advance the held word when it is dropped or the output register can take it.
   assign advance    = in_valid_ff && (!keep || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && keep) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: load without reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.text_byte <= req_tdata;
         in_item_ff.node_last <= req_tlast;
      end
      if (advance && keep) begin
         out_byte_ff <= in_item_ff.text_byte;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;

endmodule

FILE: hw/rtl/tcfcut_csr.sv
module tcfcut_csr
   import tcfcut_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_strobe;

   assign csr_pready   = 1'b1;
   assign index        = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            REG_MODE:   cfg_in.mode    = csr_pwdata[0];
            REG_A_LOW:  cfg_in.low[0]  = csr_pwdata[BOUND_BITS-1:0];
            REG_A_HIGH: cfg_in.high[0] = csr_pwdata[BOUND_BITS-1:0];
            REG_B_LOW:  cfg_in.low[1]  = csr_pwdata[BOUND_BITS-1:0];
            REG_B_HIGH: cfg_in.high[1] = csr_pwdata[BOUND_BITS-1:0];
            REG_C_LOW:  cfg_in.low[2]  = csr_pwdata[BOUND_BITS-1:0];
            REG_C_HIGH: cfg_in.high[2] = csr_pwdata[BOUND_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MODE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.mode);
         REG_A_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.low[0]);
         REG_A_HIGH: csr_prdata = CSR_DATA_BITS'(cfg_ff.high[0]);
         REG_B_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.low[1]);
         REG_B_HIGH: csr_prdata = CSR_DATA_BITS'(cfg_ff.high[1]);
         REG_C_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.low[2]);
         REG_C_HIGH: csr_prdata = CSR_DATA_BITS'(cfg_ff.high[2]);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_COLUMN;
         for (int i = 0; i < RANGE_SLOTS; i++) begin
            cfg_ff.low[i]  <= LOW_RESET;
            cfg_ff.high[i] <= HIGH_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/tcfcut_core.sv
`include "text_column_field_cut_filter_defines.svh"

module tcfcut_core
   import tcfcut_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int NUM_RANGES = 3
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type item,
   input  logic     advance,
   output logic     keep
);

   localparam int CMP_BITS = (COUNT_BITS > BOUND_BITS) ? COUNT_BITS : BOUND_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   logic [COUNT_BITS-1:0] column_count_ff;
   logic [COUNT_BITS-1:0] column_count_in;
   logic [COUNT_BITS-1:0] field_count_ff;
   logic [COUNT_BITS-1:0] field_count_in;
   logic                  inside_token_ff;
   logic                  inside_token_in;

   logic [COUNT_BITS-1:0] column_inc;
   logic [COUNT_BITS-1:0] field_inc;
   logic [CMP_BITS-1:0]   probe;
   logic                  is_nl;
   logic                  is_ws;
   logic                  force_keep;
   logic                  hit;

   assign is_nl = (item.text_byte == CHAR_LF);
   assign is_ws = is_nl || (item.text_byte == CHAR_SPACE) ||
                  (item.text_byte == CHAR_TAB) || (item.text_byte == CHAR_CR);

   // saturating increments
   assign column_inc = (column_count_ff == COUNT_MAX) ? COUNT_MAX : column_count_ff + 1'b1;
   assign field_inc  = (field_count_ff == COUNT_MAX) ? COUNT_MAX : field_count_ff + 1'b1;

   always_comb begin
      column_count_in = column_count_ff;
      field_count_in  = field_count_ff;
      inside_token_in = inside_token_ff;
      force_keep      = 1'b0;
      probe           = CMP_BITS'(column_count_ff);
      if (cfg.mode == MODE_FIELD) begin
         if (is_ws) begin
            force_keep      = 1'b1;
            inside_token_in = 1'b0;
            if (is_nl) begin
               field_count_in = '0;
            end
         end else begin
            inside_token_in = 1'b1;
            if (!inside_token_ff) begin
               field_count_in = field_inc;
            end
            probe = CMP_BITS'(field_count_in);
         end
      end else begin
         if (is_nl) begin
            force_keep      = 1'b1;
            column_count_in = COUNT_ONE;
         end else begin
            column_count_in = column_inc;
         end
      end
      if (item.node_last) begin
         column_count_in = COUNT_ONE;
         field_count_in  = '0;
         inside_token_in = 1'b0;
      end
   end

   // one comparator pair per interval
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_RANGES; i++) begin
         if ((CMP_BITS'(cfg.low[i]) <= probe) && (probe <= CMP_BITS'(cfg.high[i]))) begin
            hit = 1'b1;
         end
      end
   end

   assign keep = force_keep || hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COUNT_ONE;
         field_count_ff  <= '0;
         inside_token_ff <= 1'b0;
      end else if (advance) begin
         column_count_ff <= column_count_in;
         field_count_ff  <= field_count_in;
         inside_token_ff <= inside_token_in;
      end
   end

   `TCF_ASSERT_ALWAYS(a_column_nonzero, column_count_ff != '0, "column count reached zero")
   `TCF_ASSERT_NEXT(a_node_end_clears, advance && item.node_last, (column_count_ff == COUNT_ONE) && (field_count_ff == '0) && !inside_token_ff, "counters not cleared after node end")
   `TCF_ASSERT_NEXT(a_newline_column, advance && !item.node_last && (cfg.mode == MODE_COLUMN) && is_nl, column_count_ff == COUNT_ONE, "column not restarted by newline")
   `TCF_ASSERT_NEXT(a_token_counts, advance && !item.node_last && (cfg.mode == MODE_FIELD) && !is_ws, inside_token_ff && (field_count_ff != '0), "token byte left no field number")

endmodule

FILE: dv/text_column_field_cut_filter_tb.sv
`timescale 1ns / 100ps

module text_column_field_cut_filter_tb;
   import tcfcut_pkg::*;

   localparam int                    STALL_LIMIT = 4000;
   localparam int                    PRINT_LIMIT = 40;
   localparam logic [BOUND_BITS-1:0] COUNT_TOP   = 16'hFFFF;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;   // [7:0] text_byte
   logic                     req_tlast   = 1'b0; // node_last
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [7:0]               rsp_tdata;          // [7:0] kept_byte
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   text_column_field_cut_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the cut settings, kept in step with every register write.
   logic                  cut_mode = MODE_COLUMN;
   logic [BOUND_BITS-1:0] cut_low  [RANGE_SLOTS] = '{default: LOW_RESET};
   logic [BOUND_BITS-1:0] cut_high [RANGE_SLOTS] = '{default: HIGH_RESET};

   // Shadow copy of the position counters.
   logic [BOUND_BITS-1:0] col_pos   = 16'd1;
   logic [BOUND_BITS-1:0] field_num = 16'd0;
   logic                  in_token  = 1'b0;

   // Kept words predicted but not yet seen on the result stream, oldest first.
   logic [7:0] kept_due [$];
   logic [7:0] kept_want;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int mismatch_count    = 0;
   int words_sent        = 0;
   int kept_checked      = 0;
   int settings_applied  = 0;
   int quiet_cycles      = 0;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic in_window(input logic [BOUND_BITS-1:0] n);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < RANGE_SLOTS; k++)
         if (cut_low[k] <= n && n <= cut_high[k])
            hit = 1'b1;
      return hit;
   endfunction

   // Advance the shadow counters by one word and tell whether the word is kept.
   function automatic logic predict_cut(input logic [7:0] text, input logic last);
      logic keep;
      if (cut_mode == MODE_COLUMN) begin
         if (text == CHAR_LF) begin
            keep    = 1'b1;
            col_pos = 16'd1;
         end else begin
            keep = in_window(col_pos);
            if (col_pos != COUNT_TOP)
               col_pos = col_pos + 16'd1;
         end
      end else if (text == CHAR_SPACE || text == CHAR_TAB || text == CHAR_CR
                   || text == CHAR_LF) begin
         keep     = 1'b1;
         in_token = 1'b0;
         if (text == CHAR_LF)
            field_num = 16'd0;
      end else begin
         if (!in_token) begin
            if (field_num != COUNT_TOP)
               field_num = field_num + 16'd1;
            in_token = 1'b1;
         end
         keep = in_window(field_num);
      end
      // Node end: restart every counter after the word itself is handled.
      if (last) begin
         col_pos   = 16'd1;
         field_num = 16'd0;
         in_token  = 1'b0;
      end
      return keep;
   endfunction

   // Offer one word, idling first at the sender's rate, and hold it until taken.
   task automatic send_text_byte(input logic [7:0] text, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= text;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (predict_cut(text, last))
         kept_due.push_back(text);
      words_sent++;
   endtask

   // One APB transfer: setup cycle, access cycle until pready, then the bus returns to idle.
   task automatic csr_access(input logic is_write, input reg_index_type idx,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_BITS'(4 * int'(idx));
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_cut_reg(input reg_index_type idx, input logic [BOUND_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] unused;
      int                       slot;
      csr_access(1'b1, idx, CSR_DATA_BITS'(value), unused);
      slot = (int'(idx) - 1) >> 1;
      if (idx == REG_MODE)
         cut_mode = value[0];
      else if (idx[0])
         cut_low[slot] = value;
      else
         cut_high[slot] = value;
   endtask

   // Read every register back and compare with the shadow copy.
   task automatic check_regs();
      logic [CSR_DATA_BITS-1:0] got;
      logic [CSR_DATA_BITS-1:0] want;
      reg_index_type            idx;
      int                       slot;
      for (int i = REG_MODE; i <= REG_C_HIGH; i++) begin
         idx  = reg_index_type'(i);
         slot = (i - 1) >> 1;
         if (idx == REG_MODE)
            want = CSR_DATA_BITS'(cut_mode);
         else if (idx[0])
            want = CSR_DATA_BITS'(cut_low[slot]);
         else
            want = CSR_DATA_BITS'(cut_high[slot]);
         csr_access(1'b0, idx, '0, got);
         if (got !== want)
            report_mismatch($sformatf("register %s read 0x%08h, want 0x%08h",
                                      idx.name(), got, want));
      end
   endtask

   // Reprogram the filter. Drain every pending kept word first, then let a
   // dropped word still in the pipe clear out before touching the registers.
   task automatic set_cut(input logic mode,
                          input logic [BOUND_BITS-1:0] a_lo, input logic [BOUND_BITS-1:0] a_hi,
                          input logic [BOUND_BITS-1:0] b_lo, input logic [BOUND_BITS-1:0] b_hi,
                          input logic [BOUND_BITS-1:0] c_lo, input logic [BOUND_BITS-1:0] c_hi);
      req_tvalid <= 1'b0;
      while (kept_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      write_cut_reg(REG_MODE, BOUND_BITS'(mode));
      write_cut_reg(REG_A_LOW, a_lo);
      write_cut_reg(REG_A_HIGH, a_hi);
      write_cut_reg(REG_B_LOW, b_lo);
      write_cut_reg(REG_B_HIGH, b_hi);
      write_cut_reg(REG_C_LOW, c_lo);
      write_cut_reg(REG_C_HIGH, c_hi);
      check_regs();
      settings_applied++;
   endtask

   // Registers: reset values first, then both extremes of every bound.
   task automatic test_register_access();
      check_regs();
      set_cut(MODE_FIELD, 16'd0, COUNT_TOP, 16'd0, COUNT_TOP, 16'd0, COUNT_TOP);
      set_cut(MODE_COLUMN, COUNT_TOP, 16'd0, COUNT_TOP, 16'd0, COUNT_TOP, 16'd0);
   endtask

   // Column mode: columns 2..3 and 5 selected, third window empty (low above high).
   // Newline is always kept and restarts at column 1; CR and space are plain bytes.
   task automatic test_column_directed();
      set_cut(MODE_COLUMN, 16'd2, 16'd3, 16'd5, 16'd5, 16'd9, 16'd8);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte("c", 1'b0);
      send_text_byte(CHAR_SPACE, 1'b0);
      send_text_byte(CHAR_TAB, 1'b0);
      send_text_byte("f", 1'b0);
      send_text_byte(CHAR_LF, 1'b0);
      send_text_byte("g", 1'b0);
      send_text_byte(CHAR_CR, 1'b0);
      send_text_byte("h", 1'b1);
      send_text_byte("i", 1'b0);
   endtask

   // Field mode: fields 1 and 3, plus a window with low bound zero.
   // Each whitespace kind ends a token; newline resets the field number.
   task automatic test_field_directed();
      set_cut(MODE_FIELD, 16'd1, 16'd1, 16'd3, 16'd3, 16'd0, 16'd0);
      send_text_byte("a", 1'b0);
      send_text_byte("b", 1'b0);
      send_text_byte(CHAR_TAB, 1'b0);
      send_text_byte("c", 1'b0);
      send_text_byte(CHAR_SPACE, 1'b0);
      send_text_byte("e", 1'b0);
      send_text_byte(CHAR_CR, 1'b0);
      send_text_byte(CHAR_LF, 1'b0);
      send_text_byte("g", 1'b1);
   endtask

   // Switch modes in the middle of a node: each mode must resume its own counters.
   task automatic test_mode_switch();
      set_cut(MODE_FIELD, 16'd2, 16'd2, 16'd1, 16'd0, 16'd1, 16'd0);
      send_text_byte("a", 1'b0);
      send_text_byte(CHAR_SPACE, 1'b0);
      send_text_byte("b", 1'b0);
      set_cut(MODE_COLUMN, 16'd2, 16'd2, 16'd1, 16'd0, 16'd1, 16'd0);
      send_text_byte("c", 1'b0);
      send_text_byte("d", 1'b0);
      set_cut(MODE_FIELD, 16'd2, 16'd2, 16'd1, 16'd0, 16'd1, 16'd0);
      send_text_byte("e", 1'b0);
      send_text_byte("f", 1'b1);
   endtask

   // Random text under four cut settings: select-all, select-nothing, two random.
   task automatic test_random_text(input int items);
      logic [BOUND_BITS-1:0] lo [RANGE_SLOTS];
      logic [BOUND_BITS-1:0] hi [RANGE_SLOTS];
      logic [7:0]            text;
      int                    roll;
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < RANGE_SLOTS; k++) begin
            roll = $urandom_range(9);
            if (s == 0) begin
               lo[k] = 16'd0;
               hi[k] = COUNT_TOP;
            end else if (s == 1) begin
               lo[k] = COUNT_TOP;
               hi[k] = 16'd0;
            end else if (roll == 0) begin
               lo[k] = 16'd0;
               hi[k] = BOUND_BITS'($urandom_range(8));
            end else if (roll == 1) begin
               lo[k] = BOUND_BITS'($urandom_range(65535));
               hi[k] = COUNT_TOP;
            end else if (roll == 2) begin
               lo[k] = BOUND_BITS'($urandom_range(20, 2));
               hi[k] = lo[k] - BOUND_BITS'($urandom_range(int'(lo[k]), 1));
            end else begin
               lo[k] = BOUND_BITS'($urandom_range(12, 1));
               hi[k] = lo[k] + BOUND_BITS'($urandom_range(8));
            end
         end
         set_cut(1'($urandom_range(1)), lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
         for (int n = 0; n < items / 4; n++) begin
            // Mostly words of letters split by whitespace, with some raw bytes.
            roll = $urandom_range(99);
            if (roll < 6)
               text = CHAR_LF;
            else if (roll < 14)
               text = CHAR_SPACE;
            else if (roll < 17)
               text = CHAR_TAB;
            else if (roll < 19)
               text = CHAR_CR;
            else if (roll < 70)
               text = 8'("a" + $urandom_range(25));
            else
               text = 8'($urandom_range(255));
            send_text_byte(text, $urandom_range(29) == 0);
         end
      end
   endtask

   // Result side: stall at the receiver's rate and check each kept word in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (kept_due.size() == 0) begin
               report_mismatch($sformatf("kept word 0x%02h with none expected", rsp_tdata));
            end else begin
               kept_want = kept_due.pop_front();
               if (rsp_tdata !== kept_want)
                  report_mismatch($sformatf("kept word 0x%02h, want 0x%02h",
                                            rsp_tdata, kept_want));
               kept_checked++;
            end
         end
      end
   end

   // Watchdog: end the run if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d kept words outstanding",
                  STALL_LIMIT, kept_due.size());
         $display("text_column_field_cut_filter test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles often less than the receiver: results back up.
      sender_idle_pct   = 27;
      receiver_idle_pct = 68;
      test_register_access();
      test_column_directed();
      test_field_directed();
      test_mode_switch();
      test_random_text(400);

      // Receiver keeps up, sender starves the pipe.
      sender_idle_pct   = 68;
      receiver_idle_pct = 27;
      test_random_text(400);

      // Full rate on both sides.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_text(400);

      // Drop valid, drain what is still expected, then give the pipe time to go quiet.
      req_tvalid <= 1'b0;
      while (kept_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d words under %0d cut settings; checked %0d kept words.",
               words_sent, settings_applied, kept_checked);
      $display("Covered column and field modes, mode switches, empty and full windows, %s%0d",
               "node ends and register readback; mismatches: ", mismatch_count);
      if (mismatch_count == 0)
         $display("text_column_field_cut_filter test passed");
      else
         $display("text_column_field_cut_filter test failed");
      $finish;
   end

endmodule
